### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define MKH_ASSERT_CLK(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// assertion on the block clock and reset
`define MKH_ASSERT(lbl, prop) \
	`MKH_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

### rtl/mkh_pkg.sv
`timescale 1ns / 1ps

package mkh_pkg;

	localparam logic [31:0] SEED_RESET = 32'h9747b28c;
	localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2     = 32'h1b873593;
	localparam logic [31:0] FOLD_ADD   = 32'he6546b64;
	localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;

	// byte counts
	localparam logic [2:0] CNT_NONE  = 3'd0;
	localparam logic [2:0] CNT_ONE   = 3'd1;
	localparam logic [2:0] CNT_TWO   = 3'd2;
	localparam logic [2:0] CNT_THREE = 3'd3;
	localparam logic [2:0] CNT_FULL  = 3'd4;

	localparam int MKH_FIFO_DEPTH = 4;

	// premixed word on its way from front to back
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  cnt;
		logic        last;
	} mkh_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} mkh_qstat_t;

endpackage

### rtl/mkh_word_if.sv
`timescale 1ns / 1ps

interface mkh_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last;

	modport source (output valid, output data_word, output byte_count, output last,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last,
		output ready);
endinterface

### rtl/mkh_hash_if.sv
`timescale 1ns / 1ps

interface mkh_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash;

	modport source (output valid, output hash, input ready);
	modport sink (input valid, input hash, output ready);
endinterface

### rtl/mkh_fifo.sv
`timescale 1ns / 1ps

module mkh_fifo
	import mkh_pkg::*;
#(
	parameter int DEPTH = MKH_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mkh_entry_t push_data,
	input  logic       pop,
	output mkh_entry_t head,
	output mkh_qstat_t stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	mkh_entry_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem[rd_ptr_q];
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

endmodule

### rtl/mkh_front.sv
`timescale 1ns / 1ps

module mkh_front
	import mkh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mkh_word_if.sink   key,
	input  mkh_qstat_t qstat,
	output logic       push,
	output mkh_entry_t push_data
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [2:0]  cnt_s1;
	logic        last_s1;

	logic        valid_s2;
	logic [31:0] k1_s2;
	logic [2:0]  cnt_s2;
	logic        last_s2;

	logic [2:0]  eff_cnt;
	logic [31:0] mask;
	logic        s2_free;
	logic        s1_move;
	logic [31:0] k1_rot;

	// short count only counts on the last word
	always_comb begin
		eff_cnt = key.byte_count;
		if (!key.last || key.byte_count > CNT_FULL) begin
			eff_cnt = CNT_FULL;
		end
		case (eff_cnt)
			CNT_NONE:  mask = 32'h0000_0000;
			CNT_ONE:   mask = 32'h0000_00ff;
			CNT_TWO:   mask = 32'h0000_ffff;
			CNT_THREE: mask = 32'h00ff_ffff;
			default:   mask = 32'hffff_ffff;
		endcase
	end

	assign push      = valid_s2 && !qstat.full;
	assign s2_free   = !valid_s2 || push;
	assign s1_move   = valid_s1 && s2_free;
	assign key.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (key.ready) begin
				valid_s1 <= key.valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key.valid && key.ready) begin
			word_s1 <= key.data_word & mask;
			cnt_s1  <= eff_cnt;
			last_s1 <= key.last;
		end
		if (s1_move) begin
			k1_s2  <= word_s1 * MIX_C1;
			cnt_s2 <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign k1_rot         = {k1_s2[16:0], k1_s2[31:17]};
	assign push_data.k    = k1_rot * MIX_C2;
	assign push_data.cnt  = cnt_s2;
	assign push_data.last = last_s2;

endmodule

### rtl/mkh_back.sv
`timescale 1ns / 1ps

module mkh_back
	import mkh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  mkh_entry_t  head,
	input  mkh_qstat_t  qstat,
	output logic        pop,
	mkh_hash_if.source  result
);

	logic [31:0] h_q;
	logic [31:0] len_q;

	logic        valid_s1;
	logic [31:0] x1_s1;
	logic        valid_s2;
	logic [31:0] m1_s2;
	logic        valid_s3;
	logic [31:0] m2_s3;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [31:0] hx;
	logic [31:0] hr;
	logic [31:0] h_mix;
	logic [31:0] len_new;
	logic [31:0] fin;
	logic [31:0] m1_x;
	logic        out_free;
	logic        s3_free;
	logic        s2_free;
	logic        s1_free;
	logic        s3_move;
	logic        s2_move;
	logic        s1_move;
	logic        fin_load;

	// full word folds with rotate and multiply-add, tail only xors
	always_comb begin
		hx      = h_q ^ head.k;
		hr      = {hx[18:0], hx[31:19]};
		h_mix   = (head.cnt == CNT_FULL) ? (hr + {hr[29:0], 2'b00} + FOLD_ADD) : hx;
		len_new = len_q + 32'(head.cnt);
		fin     = h_mix ^ len_new;
		m1_x    = m1_s2 ^ (m1_s2 >> 13);
	end

	assign out_free = !out_valid_q || result.ready;
	assign s3_move  = valid_s3 && out_free;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_move  = valid_s2 && s3_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_move  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign pop      = !qstat.empty && (!head.last || s1_free);
	assign fin_load = pop && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= SEED_RESET;
			len_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				h_q   <= head.last ? seed : h_mix;
				len_q <= head.last ? '0 : len_new;
			end
			if (s1_free) begin
				valid_s1 <= fin_load;
			end
			if (s2_free) begin
				valid_s2 <= s1_move;
			end
			if (s3_free) begin
				valid_s3 <= s2_move;
			end
			if (out_free) begin
				out_valid_q <= s3_move;
			end
		end
	end

	// avalanche: xor-shift, multiply, xor-shift and multiply, final xor-shift
	always_ff @(posedge clk) begin
		if (fin_load) begin
			x1_s1 <= fin ^ (fin >> 16);
		end
		if (s1_move) begin
			m1_s2 <= x1_s1 * FIN_M1;
		end
		if (s2_move) begin
			m2_s3 <= m1_x * FIN_M2;
		end
		if (s3_move) begin
			hash_q <= m2_s3 ^ (m2_s3 >> 16);
		end
	end

	assign result.valid = out_valid_q;
	assign result.hash  = hash_q;

endmodule

### rtl/murmur3_32_key_hash.sv
`timescale 1ns / 1ps
// MurmurHash3 x86_32 of a key streamed as 32-bit little-endian words.
// key channel: data_word holds four key bytes, first byte in bits 7..0;
// byte_count gives the valid bytes, below 4 only on the last beat (else
// taken as 4); last closes the key. Bytes above byte_count are ignored.
// result channel: one beat per key carrying the finished hash.
// seed_we/seed_wdata load the seed; the running hash reloads from the seed
// when a key finishes, so a new seed applies to the key after the next one
// closes. Write it only while no key is in flight.
// Throughput: one key word per cycle while the queue is not full. The
// front premixes each word in two multiplier stages and queues it; the
// back folds it into the running hash register and sends each finished
// key through the avalanche stages and output register to result.valid.
// Reset clears all pipelines and the queue; the running hash and the seed
// come up at 0x9747b28c. When the receiver stalls, the hash holds; the
// avalanche stages and queue fill, then key.ready drops.
module murmur3_32_key_hash
	import mkh_pkg::*;
#(
	parameter int FIFO_DEPTH = MKH_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	mkh_word_if.sink    key,
	mkh_hash_if.source  result
);

	logic [31:0] seed_q;
	logic        push;
	logic        pop;
	mkh_entry_t  push_data;
	mkh_entry_t  head;
	mkh_qstat_t  qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	mkh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	mkh_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	mkh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.seed   (seed_q),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule

### rtl/mkh_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mkh_checker
	import mkh_pkg::*;
#(
	parameter int FIFO_DEPTH = MKH_FIFO_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        key_valid,
	input logic        key_ready,
	input logic        key_last,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_hash
);

	// front stages, queue, avalanche stages and output register
	localparam int PEND_MAX = FIFO_DEPTH + 6;
	localparam int PW       = $clog2(PEND_MAX + 1);

	logic [PW-1:0] pending_q;
	logic          key_end;
	logic          res_take;

	assign key_end  = key_valid && key_ready && key_last;
	assign res_take = result_valid && result_ready;

	// keys closed at the input but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (key_end && !res_take) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_take && !key_end) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`MKH_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result_hash))
	`MKH_ASSERT(a_no_orphan, result_valid |-> pending_q != '0)
	`MKH_ASSERT(a_pending_bound, 32'(pending_q) <= PEND_MAX)

endmodule

bind murmur3_32_key_hash mkh_checker #(
	.FIFO_DEPTH (FIFO_DEPTH)
) u_mkh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.key_valid    (key.valid),
	.key_ready    (key.ready),
	.key_last     (key.last),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_hash  (result.hash)
);

### sim/murmur3_32_key_hash_tb.sv
`timescale 1ns / 1ps

module murmur3_32_key_hash_tb;
	import mkh_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} key_word_t;

	logic        clk;
	logic        arst_n;
	logic        seed_we;
	logic [31:0] seed_wdata;

	mkh_word_if key_bus();
	mkh_hash_if hash_bus();

	murmur3_32_key_hash u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.key        (key_bus),
		.result     (hash_bus)
	);

	// predictor state
	logic [31:0] model_seed;
	logic [31:0] model_hash;
	logic [31:0] model_len;

	key_word_t   word_queue[$];
	logic [31:0] hash_queue[$];

	int src_idle_pct;
	int sink_stall_pct;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int errors;
	int words_queued;
	int words_taken;
	int keys_queued;
	int hashes_seen;
	int seeds_written;
	int cycles;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] scramble_word(input logic [31:0] k);
		logic [31:0] t;
		t = k * MIX_C1;
		t = rol32(t, 15);
		return t * MIX_C2;
	endfunction

	function automatic logic [31:0] finalize_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * FIN_M1;
		t = t ^ (t >> 13);
		t = t * FIN_M2;
		return t ^ (t >> 16);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d hashes outstanding", cycles,
				hash_queue.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// fold each accepted beat into the running hash, queue the finished hash
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] h;
		logic [31:0] mask;
		logic [2:0]  cnt;
		if (!arst_n) begin
			model_seed = SEED_RESET;
			model_hash = SEED_RESET;
			model_len  = '0;
		end else begin
			if (seed_we)
				model_seed = seed_wdata;
			if (key_bus.valid && key_bus.ready) begin
				cnt = key_bus.byte_count;
				if (cnt > CNT_FULL || !key_bus.last)
					cnt = CNT_FULL;
				h = model_hash;
				if (cnt == CNT_FULL) begin
					h ^= scramble_word(key_bus.data_word);
					h = rol32(h, 13) * 5 + FOLD_ADD;
				end else if (cnt != CNT_NONE) begin
					mask = 32'hffffffff >> (8 * (4 - cnt));
					h ^= scramble_word(key_bus.data_word & mask);
				end
				model_len = model_len + cnt;
				words_taken++;
				if (key_bus.last) begin
					hash_queue.push_back(finalize_hash(h ^ model_len));
					model_hash = model_seed;
					model_len  = '0;
				end else begin
					model_hash = h;
				end
			end
		end
	end

	// key word driver
	always @(posedge clk or negedge arst_n) begin
		key_word_t w;
		if (!arst_n) begin
			key_bus.valid      <= 1'b0;
			key_bus.data_word  <= '0;
			key_bus.byte_count <= CNT_NONE;
			key_bus.last       <= 1'b0;
		end else if (!key_bus.valid || key_bus.ready) begin
			if (word_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				w = word_queue.pop_front();
				key_bus.valid      <= 1'b1;
				key_bus.data_word  <= w.data_word;
				key_bus.byte_count <= w.byte_count;
				key_bus.last       <= w.last;
			end else begin
				key_bus.valid <= 1'b0;
			end
		end
	end

	// long result hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// hash monitor
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			hash_bus.ready <= 1'b0;
		end else begin
			if (hash_bus.valid && hash_bus.ready) begin
				hashes_seen++;
				if (hash_queue.size() == 0) begin
					errors++;
					$error("hash beat with none expected: actual %08h", hash_bus.hash);
				end else begin
					want = hash_queue.pop_front();
					if (want !== hash_bus.hash) begin
						errors++;
						$error("hash mismatch: expected %08h, actual %08h", want,
							hash_bus.hash);
					end
				end
			end
			hash_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic queue_word(input logic [31:0] d, input logic [2:0] c, input logic l);
		key_word_t w;
		w.data_word  = d;
		w.byte_count = c;
		w.last       = l;
		word_queue.push_back(w);
		words_queued++;
		if (l)
			keys_queued++;
	endtask

	// mostly full body words; noisy keys get odd counts on body and tail
	task automatic queue_random_key(input int max_words);
		int  n;
		bit  noisy;
		n     = $urandom_range(max_words);
		noisy = ($urandom_range(9) == 0);
		for (int i = 0; i < n; i++)
			queue_word($urandom, noisy ? 3'($urandom_range(7)) : CNT_FULL, 1'b0);
		queue_word($urandom, 3'($urandom_range(noisy ? 7 : 4)), 1'b1);
	endtask

	task automatic wait_idle();
		while (word_queue.size() != 0 || key_bus.valid || hash_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(posedge clk);
		seed_we    <= 1'b1;
		seed_wdata <= v;
		@(posedge clk);
		seed_we    <= 1'b0;
		seeds_written++;
		@(negedge clk);
	endtask

	task automatic run_phase(input int n_words, input int src, input int snk,
		input int max_words, input bit hold);
		int start;
		start          = words_queued;
		src_idle_pct   = src;
		sink_stall_pct = snk;
		while (words_queued - start < n_words)
			queue_random_key(max_words);
		if (hold)
			hold_requests++;
		wait_idle();
	endtask

	initial begin
		arst_n             = 1'b0;
		seed_we            = 1'b0;
		seed_wdata         = '0;
		key_bus.valid      = 1'b0;
		key_bus.data_word  = '0;
		key_bus.byte_count = CNT_NONE;
		key_bus.last       = 1'b0;
		hash_bus.ready     = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed keys under the reset seed
		queue_word(32'hdeadbeef, CNT_NONE, 1'b1);
		queue_word(32'hffffffab, CNT_ONE, 1'b1);
		queue_word(32'h00000000, CNT_TWO, 1'b1);
		queue_word(32'hffffffff, CNT_THREE, 1'b1);
		queue_word(32'hffffffff, CNT_FULL, 1'b1);
		queue_word(32'h00000000, CNT_FULL, 1'b0);
		queue_word(32'h00000000, CNT_NONE, 1'b1);
		// short and oversized counts on body words count as full, as do oversized counts on last words
		queue_word(32'h12345678, CNT_NONE, 1'b0);
		queue_word(32'h9abcdef0, CNT_ONE, 1'b0);
		queue_word(32'h0f1e2d3c, CNT_THREE, 1'b0);
		queue_word(32'h4b5a6978, 3'd5, 1'b0);
		queue_word(32'h87654321, CNT_FULL, 1'b0);
		queue_word(32'h55aa55aa, CNT_TWO, 1'b1);
		queue_word(32'ha5a5a5a5, 3'd5, 1'b1);
		queue_word(32'h5a5a5a5a, 3'd6, 1'b1);
		queue_word(32'h80000001, 3'd7, 1'b1);
		wait_idle();

		// seed change in the middle of a key
		queue_word(32'hcafef00d, CNT_FULL, 1'b0);
		wait_idle();
		write_seed(32'h00000000);
		queue_word(32'h0badf00d, CNT_THREE, 1'b1);
		queue_word(32'h00000001, CNT_ONE, 1'b1);
		queue_word(32'hffffffff, CNT_NONE, 1'b1);
		wait_idle();
		write_seed(32'hffffffff);
		queue_word(32'h00000000, CNT_NONE, 1'b1);
		queue_word(32'h7fffffff, CNT_FULL, 1'b1);
		wait_idle();

		run_phase(150, 0, 0, 6, 1'b0);
		write_seed(32'h00000000);
		run_phase(150, 60, 0, 6, 1'b0);
		write_seed($urandom);
		run_phase(150, 0, 60, 6, 1'b0);
		write_seed(32'hffffffff);
		run_phase(150, 6, 6, 6, 1'b0);
		write_seed($urandom);
		// short keys with the receiver held off so the pipeline backs up
		run_phase(150, 0, 0, 1, 1'b1);
		write_seed(SEED_RESET);
		run_phase(100, 30, 30, 20, 1'b0);
		write_seed($urandom);
		run_phase(100, 0, 0, 3, 1'b1);

		$display("%0d key words in %0d keys, %0d hashes checked, %0d seed writes",
			words_taken, keys_queued, hashes_seen, seeds_written);
		$display("mixes of sender gaps, receiver stalls and a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
